FILE: rtl/jbt_pkg.sv
// ----------------------------------------------------------------------------
// jbt_pkg
// Shared types, character codes and helper functions for the JSON byte
// tokenizer.
// ----------------------------------------------------------------------------
package jbt_pkg;

  localparam int OFFSET_BITS = 16;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_STRING  = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_KEYWORD = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    KIND_LBRACE   = 4'd0,
    KIND_RBRACE   = 4'd1,
    KIND_LBRACKET = 4'd2,
    KIND_RBRACKET = 4'd3,
    KIND_COLON    = 4'd4,
    KIND_COMMA    = 4'd5,
    KIND_STRING   = 4'd6,
    KIND_TRUE     = 4'd7,
    KIND_FALSE    = 4'd8,
    KIND_NULL     = 4'd9,
    KIND_NUMBER   = 4'd10,
    KIND_END      = 4'd11,
    KIND_UNKNOWN  = 4'd12
  } kind_t;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_N        = 8'h6E;

  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  pick;
    logic [2:0]  matched;
    offset_t     pos;
    offset_t     start;
    offset_t     run;
  } scan_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] len;
  } token_t;

  // Results of one byte: optional string/number token, a run of unknowns,
  // then an optional closing token.
  typedef struct packed {
    logic        pre_v;
    token_t      pre;
    logic [2:0]  unk_cnt;
    logic        tail_v;
    kind_t       tail_kind;
  } tok_list_t;

  function automatic offset_t sat_inc(offset_t v);
    if (v == '1) begin
      return v;
    end
    return v + offset_t'(1);
  endfunction

  function automatic logic [15:0] out16(offset_t v);
    logic [OFFSET_BITS+15:0] w;
    w = {16'd0, v};
    if (w > (OFFSET_BITS+16)'(17'h0FFFF)) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] pick);
    return (pick == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] kw_char(logic [1:0] pick, logic [2:0] idx);
    logic [7:0] c;
    c = CH_NUL;
    case (pick)
      KW_TRUE: begin
        case (idx)
          3'd0:    c = 8'h74;
          3'd1:    c = 8'h72;
          3'd2:    c = 8'h75;
          3'd3:    c = 8'h65;
          default: c = CH_NUL;
        endcase
      end
      KW_FALSE: begin
        case (idx)
          3'd0:    c = 8'h66;
          3'd1:    c = 8'h61;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h73;
          3'd4:    c = 8'h65;
          default: c = CH_NUL;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    c = 8'h6E;
          3'd1:    c = 8'h75;
          3'd2:    c = 8'h6C;
          3'd3:    c = 8'h6C;
          default: c = CH_NUL;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/jbt_step.sv
// ----------------------------------------------------------------------------
// jbt_step
// Next-state and token list for one document byte, purely combinational.
// ----------------------------------------------------------------------------
module jbt_step (
  input  jbt_pkg::scan_state_t cur,
  input  logic [7:0]           byte_in,
  output jbt_pkg::scan_state_t nxt,
  output jbt_pkg::tok_list_t   toks
);

  logic       restart;
  logic       ended;
  logic [1:0] pick_eff;
  logic [2:0] held;
  logic       is_digit;

  assign is_digit = (byte_in >= jbt_pkg::CH_ZERO) && (byte_in <= jbt_pkg::CH_NINE);
  assign pick_eff = (cur.pick == 2'd3) ? jbt_pkg::KW_NULL : cur.pick;
  assign held     = (cur.matched > 3'd4) ? 3'd4 : cur.matched;

  always_comb begin
    nxt     = cur;
    toks    = '0;
    restart = 1'b0;
    ended   = 1'b0;

    case (cur.mode)
      jbt_pkg::MODE_STRING: begin
        if (byte_in == jbt_pkg::CH_QUOTE || byte_in == jbt_pkg::CH_NUL) begin
          toks.pre_v     = 1'b1;
          toks.pre.kind  = jbt_pkg::KIND_STRING;
          toks.pre.start = jbt_pkg::out16(cur.start);
          toks.pre.len   = jbt_pkg::out16(cur.run);
          nxt.mode       = jbt_pkg::MODE_IDLE;
          restart        = (byte_in == jbt_pkg::CH_NUL);
        end else begin
          nxt.run = jbt_pkg::sat_inc(cur.run);
        end
      end
      jbt_pkg::MODE_NUMBER: begin
        if (is_digit || byte_in == jbt_pkg::CH_DOT) begin
          nxt.run = jbt_pkg::sat_inc(cur.run);
        end else begin
          toks.pre_v     = 1'b1;
          toks.pre.kind  = jbt_pkg::KIND_NUMBER;
          toks.pre.start = jbt_pkg::out16(cur.start);
          toks.pre.len   = jbt_pkg::out16(cur.run);
          restart        = 1'b1;
        end
      end
      jbt_pkg::MODE_KEYWORD: begin
        if (held < jbt_pkg::kw_len(pick_eff) && byte_in == jbt_pkg::kw_char(pick_eff, held)) begin
          nxt.matched = held + 3'd1;
          if (held + 3'd1 == jbt_pkg::kw_len(pick_eff)) begin
            toks.tail_v = 1'b1;
            case (pick_eff)
              jbt_pkg::KW_TRUE:  toks.tail_kind = jbt_pkg::KIND_TRUE;
              jbt_pkg::KW_FALSE: toks.tail_kind = jbt_pkg::KIND_FALSE;
              default:           toks.tail_kind = jbt_pkg::KIND_NULL;
            endcase
            nxt.mode = jbt_pkg::MODE_IDLE;
          end
        end else begin
          // every held keyword byte turns into an unknown token
          toks.unk_cnt = held;
          restart      = 1'b1;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    // byte handled as the first byte of a token
    if (restart) begin
      nxt.mode = jbt_pkg::MODE_IDLE;
      unique case (byte_in)
        jbt_pkg::CH_NUL: begin
          toks.tail_v    = 1'b1;
          toks.tail_kind = jbt_pkg::KIND_END;
          ended          = 1'b1;
        end
        jbt_pkg::CH_LBRACE: begin
          toks.tail_v    = 1'b1;
          toks.tail_kind = jbt_pkg::KIND_LBRACE;
        end
        jbt_pkg::CH_RBRACE: begin
          toks.tail_v    = 1'b1;
          toks.tail_kind = jbt_pkg::KIND_RBRACE;
        end
        jbt_pkg::CH_LBRACKET: begin
          toks.tail_v    = 1'b1;
          toks.tail_kind = jbt_pkg::KIND_LBRACKET;
        end
        jbt_pkg::CH_RBRACKET: begin
          toks.tail_v    = 1'b1;
          toks.tail_kind = jbt_pkg::KIND_RBRACKET;
        end
        jbt_pkg::CH_COLON: begin
          toks.tail_v    = 1'b1;
          toks.tail_kind = jbt_pkg::KIND_COLON;
        end
        jbt_pkg::CH_COMMA: begin
          toks.tail_v    = 1'b1;
          toks.tail_kind = jbt_pkg::KIND_COMMA;
        end
        jbt_pkg::CH_SPACE, jbt_pkg::CH_NL: begin
        end
        jbt_pkg::CH_QUOTE: begin
          nxt.mode  = jbt_pkg::MODE_STRING;
          nxt.start = jbt_pkg::sat_inc(cur.pos);
          nxt.run   = '0;
        end
        jbt_pkg::CH_T: begin
          nxt.mode    = jbt_pkg::MODE_KEYWORD;
          nxt.pick    = jbt_pkg::KW_TRUE;
          nxt.matched = 3'd1;
        end
        jbt_pkg::CH_F: begin
          nxt.mode    = jbt_pkg::MODE_KEYWORD;
          nxt.pick    = jbt_pkg::KW_FALSE;
          nxt.matched = 3'd1;
        end
        jbt_pkg::CH_N: begin
          nxt.mode    = jbt_pkg::MODE_KEYWORD;
          nxt.pick    = jbt_pkg::KW_NULL;
          nxt.matched = 3'd1;
        end
        default: begin
          if (is_digit) begin
            nxt.mode  = jbt_pkg::MODE_NUMBER;
            nxt.start = cur.pos;
            nxt.run   = jbt_pkg::offset_t'(1);
          end else begin
            toks.tail_v    = 1'b1;
            toks.tail_kind = jbt_pkg::KIND_UNKNOWN;
          end
        end
      endcase
    end

    nxt.pos = ended ? '0 : jbt_pkg::sat_inc(cur.pos);
  end

endmodule

FILE: rtl/json_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// json_byte_tokenizer
// Byte-serial JSON tokenizer: one document byte in, zero to five tokens out.
// The first token of a byte appears on out_* in the cycle after its byte is transferred.
// One byte per cycle while each byte yields at most one token and out_ready is high;
// a byte yielding several tokens holds the result register until all are taken.
// Reset (rst_n low, synchronous) clears scan state, position and results.
// ----------------------------------------------------------------------------
module json_byte_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  jbt_pkg::scan_state_t state_r;
  jbt_pkg::scan_state_t state_nxt;
  jbt_pkg::tok_list_t   toks_nxt;

  logic           pre_v_r;
  jbt_pkg::token_t pre_r;
  logic [2:0]     unk_r;
  logic           tail_v_r;
  jbt_pkg::kind_t tail_kind_r;

  logic [2:0] remaining;
  logic       in_xfer;
  logic       out_xfer;

  jbt_step u_step (
    .cur     (state_r),
    .byte_in (in_byte),
    .nxt     (state_nxt),
    .toks    (toks_nxt)
  );

  assign remaining = {2'b00, pre_v_r} + unk_r + {2'b00, tail_v_r};
  assign out_valid = pre_v_r || (unk_r != 3'd0) || tail_v_r;
  assign out_last_of_run = (remaining == 3'd1);
  assign in_ready  = !out_valid || (out_ready && out_last_of_run);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  always_comb begin
    if (pre_v_r) begin
      out_token_kind   = pre_r.kind;
      out_token_start  = pre_r.start;
      out_token_length = pre_r.len;
    end else if (unk_r != 3'd0) begin
      out_token_kind   = jbt_pkg::KIND_UNKNOWN;
      out_token_start  = '0;
      out_token_length = '0;
    end else begin
      out_token_kind   = tail_kind_r;
      out_token_start  = '0;
      out_token_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= '0;
      pre_v_r  <= 1'b0;
      unk_r    <= '0;
      tail_v_r <= 1'b0;
    end else if (in_xfer) begin
      state_r  <= state_nxt;
      pre_v_r  <= toks_nxt.pre_v;
      unk_r    <= toks_nxt.unk_cnt;
      tail_v_r <= toks_nxt.tail_v;
    end else if (out_xfer) begin
      if (pre_v_r) begin
        pre_v_r <= 1'b0;
      end else if (unk_r != 3'd0) begin
        unk_r <= unk_r - 3'd1;
      end else begin
        tail_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pre_r       <= toks_nxt.pre;
      tail_kind_r <= toks_nxt.tail_kind;
    end
  end

  // end of document restarts the offset count
  a_end_resets_pos: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_byte == jbt_pkg::CH_NUL |=> state_r.pos == '0)
    else $error("position not cleared after end of document");

  // more results of the same byte follow without a gap
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !out_last_of_run |=> out_valid)
    else $error("result run broken off early");

  // no new byte while earlier results would be left behind
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> !out_valid || (out_xfer && out_last_of_run))
    else $error("byte taken while results pending");

  // only strings and numbers carry offsets
  a_plain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != jbt_pkg::KIND_STRING
      && out_token_kind != jbt_pkg::KIND_NUMBER
      |-> out_token_start == '0 && out_token_length == '0)
    else $error("offset on a plain token");

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: JSON byte tokenizer testbench
// Feeds documents one byte per transfer through a queue-driven driver. A
// scoreboard predicts the tokens of every accepted byte and checks them,
// field by field and in order, against the result channel. A directed
// document comes first, then random well-formed documents mixed with noise
// and broken keywords and strings. Both sides stall in random bursts,
// except at the end.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int PRINT_CAP   = 40;

  // Keyword spellings, indexed by keyword select and matched count
  localparam logic [7:0] KEYWORD_BYTES [3][5] = '{
    '{"t", "r", "u", "e", 8'h00},
    '{"f", "a", "l", "s", "e"},
    '{"n", "u", "l", "l", 8'h00}
  };

  typedef struct packed {
    jbt_pkg::kind_t kind;
    logic [15:0]    start;
    logic [15:0]    len;
    logic           last;
  } token_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic        out_last_of_run;

  json_byte_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stimulus and scoreboard storage
  logic [7:0]  byte_q[$];
  token_exp_t  token_q[$];
  int          err_count = 0;
  int          quiet_cycles = 0;
  int          rand_bytes = 0;
  bit          byte_taken = 1'b0;
  bit          calm = 1'b0;
  int          tx_gap = 0;
  int          rx_gap = 0;
  int          rx_hold = 0;

  // Predictor state
  jbt_pkg::mode_t   tk_mode = jbt_pkg::MODE_IDLE;
  logic [1:0]       kw_sel = jbt_pkg::KW_TRUE;
  logic [2:0]       kw_got = 3'd0;
  jbt_pkg::offset_t cur_pos = '0;
  jbt_pkg::offset_t tok_begin = '0;
  jbt_pkg::offset_t tok_len = '0;
  token_exp_t       step_buf [5];
  int               step_n = 0;

  function automatic jbt_pkg::offset_t bump(jbt_pkg::offset_t v);
    return (v == '1) ? v : v + jbt_pkg::offset_t'(1);
  endfunction

  function automatic logic [15:0] clip16(jbt_pkg::offset_t v);
    return (v > jbt_pkg::offset_t'(16'hFFFF)) ? 16'hFFFF : 16'(v);
  endfunction

  task automatic flag_error(input string msg);
    if (err_count < PRINT_CAP) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    err_count++;
  endtask

  task automatic add_token(input jbt_pkg::kind_t kind, input jbt_pkg::offset_t s,
                           input jbt_pkg::offset_t l);
    if (step_n < 5) begin
      step_buf[step_n].kind  = kind;
      step_buf[step_n].start = clip16(s);
      step_buf[step_n].len   = clip16(l);
      step_buf[step_n].last  = 1'b0;
      step_n++;
    end
  endtask

  // Byte seen between tokens; ended is set when it closes the document
  task automatic open_token(input logic [7:0] b, input jbt_pkg::offset_t pos,
                            output bit ended);
    ended = 1'b0;
    tk_mode = jbt_pkg::MODE_IDLE;
    case (b)
      jbt_pkg::CH_NUL: begin
        add_token(jbt_pkg::KIND_END, '0, '0);
        ended = 1'b1;
      end
      jbt_pkg::CH_LBRACE:   add_token(jbt_pkg::KIND_LBRACE, '0, '0);
      jbt_pkg::CH_RBRACE:   add_token(jbt_pkg::KIND_RBRACE, '0, '0);
      jbt_pkg::CH_LBRACKET: add_token(jbt_pkg::KIND_LBRACKET, '0, '0);
      jbt_pkg::CH_RBRACKET: add_token(jbt_pkg::KIND_RBRACKET, '0, '0);
      jbt_pkg::CH_COLON:    add_token(jbt_pkg::KIND_COLON, '0, '0);
      jbt_pkg::CH_COMMA:    add_token(jbt_pkg::KIND_COMMA, '0, '0);
      jbt_pkg::CH_SPACE, jbt_pkg::CH_NL: ;
      jbt_pkg::CH_QUOTE: begin
        tk_mode = jbt_pkg::MODE_STRING;
        tok_begin = bump(pos);
        tok_len = '0;
      end
      jbt_pkg::CH_T, jbt_pkg::CH_F, jbt_pkg::CH_N: begin
        tk_mode = jbt_pkg::MODE_KEYWORD;
        kw_sel = (b == jbt_pkg::CH_T) ? jbt_pkg::KW_TRUE :
                 ((b == jbt_pkg::CH_F) ? jbt_pkg::KW_FALSE : jbt_pkg::KW_NULL);
        kw_got = 3'd1;
      end
      default: begin
        if (b >= jbt_pkg::CH_ZERO && b <= jbt_pkg::CH_NINE) begin
          tk_mode = jbt_pkg::MODE_NUMBER;
          tok_begin = pos;
          tok_len = jbt_pkg::offset_t'(1);
        end else begin
          add_token(jbt_pkg::KIND_UNKNOWN, '0, '0);
        end
      end
    endcase
  endtask

  task automatic tokenize_byte(input logic [7:0] b);
    jbt_pkg::offset_t pos;
    bit               ended;
    logic [2:0]       held;
    logic [2:0]       klen;
    pos = cur_pos;
    ended = 1'b0;
    step_n = 0;
    case (tk_mode)
      jbt_pkg::MODE_STRING: begin
        if (b == jbt_pkg::CH_QUOTE) begin
          add_token(jbt_pkg::KIND_STRING, tok_begin, tok_len);
          tk_mode = jbt_pkg::MODE_IDLE;
        end else if (b == jbt_pkg::CH_NUL) begin
          add_token(jbt_pkg::KIND_STRING, tok_begin, tok_len);
          open_token(b, pos, ended);
        end else begin
          tok_len = bump(tok_len);
        end
      end
      jbt_pkg::MODE_NUMBER: begin
        if ((b >= jbt_pkg::CH_ZERO && b <= jbt_pkg::CH_NINE) || b == jbt_pkg::CH_DOT) begin
          tok_len = bump(tok_len);
        end else begin
          add_token(jbt_pkg::KIND_NUMBER, tok_begin, tok_len);
          open_token(b, pos, ended);
        end
      end
      jbt_pkg::MODE_KEYWORD: begin
        held = (kw_got > 3'd4) ? 3'd4 : kw_got;
        klen = (kw_sel == jbt_pkg::KW_FALSE) ? 3'd5 : 3'd4;
        if (held < klen && b == KEYWORD_BYTES[kw_sel][held]) begin
          held++;
          kw_got = held;
          if (held == klen) begin
            case (kw_sel)
              jbt_pkg::KW_TRUE:  add_token(jbt_pkg::KIND_TRUE, '0, '0);
              jbt_pkg::KW_FALSE: add_token(jbt_pkg::KIND_FALSE, '0, '0);
              default:           add_token(jbt_pkg::KIND_NULL, '0, '0);
            endcase
            tk_mode = jbt_pkg::MODE_IDLE;
          end
        end else begin
          // every byte held so far becomes an unknown token
          for (int i = 0; i < held; i++) add_token(jbt_pkg::KIND_UNKNOWN, '0, '0);
          open_token(b, pos, ended);
        end
      end
      default: open_token(b, pos, ended);
    endcase
    if (ended) begin
      cur_pos = '0;
      tk_mode = jbt_pkg::MODE_IDLE;
    end else begin
      cur_pos = bump(pos);
    end
    if (step_n > 0) step_buf[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) token_q.push_back(step_buf[i]);
  endtask

  // Sender: holds a byte until its transfer, then takes the next one
  always @(negedge clk) begin : driver
    logic       nv;
    logic [7:0] nb;
    nv = in_valid;
    nb = in_byte;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (!in_valid || byte_taken) begin
      nv = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (byte_q.size() > 0) begin
        if (!calm && $urandom_range(0, 11) == 0) begin
          tx_gap = $urandom_range(1, 19) - 1;
        end else begin
          nv = 1'b1;
          nb = byte_q.pop_front();
        end
      end
    end
    byte_taken = 1'b0;
    in_valid <= nv;
    in_byte <= nb;
  end

  // Receiver: long hold-off on request, random stall bursts otherwise
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_ready <= 1'b0;
      rx_gap = $urandom_range(1, 19) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor, scoreboard and watchdog
  always @(posedge clk) begin : monitor
    token_exp_t want;
    bit         moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        tokenize_byte(in_byte);
        byte_taken = 1'b1;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (token_q.size() == 0) begin
          flag_error($sformatf("unexpected token kind %0d", out_token_kind));
        end else begin
          want = token_q.pop_front();
          if (out_token_kind !== want.kind)
            flag_error($sformatf("kind %0d, want %s", out_token_kind, want.kind.name()));
          if (out_token_start !== want.start)
            flag_error($sformatf("start %0d, want %0d", out_token_start, want.start));
          if (out_token_length !== want.len)
            flag_error($sformatf("length %0d, want %0d", out_token_length, want.len));
          if (out_last_of_run !== want.last)
            flag_error($sformatf("last_of_run %0b, want %0b", out_last_of_run, want.last));
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---- stimulus generators ----
  task automatic put(input logic [7:0] b);
    byte_q.push_back(b);
    rand_bytes++;
  endtask

  task automatic put_ws();
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      put($urandom_range(0, 1) ? jbt_pkg::CH_SPACE : jbt_pkg::CH_NL);
  endtask

  task automatic put_string_body();
    logic [7:0] c;
    repeat ($urandom_range(0, 6)) begin
      do c = 8'($urandom_range(1, 255)); while (c == jbt_pkg::CH_QUOTE);
      put(c);
    end
  endtask

  task automatic put_number();
    put(8'($urandom_range(jbt_pkg::CH_ZERO, jbt_pkg::CH_NINE)));
    repeat ($urandom_range(0, 5))
      put(($urandom_range(0, 9) == 0) ? jbt_pkg::CH_DOT :
          8'($urandom_range(jbt_pkg::CH_ZERO, jbt_pkg::CH_NINE)));
  endtask

  task automatic put_keyword(input int sel, input int upto);
    for (int i = 0; i < upto; i++) put(KEYWORD_BYTES[sel][i]);
  endtask

  task automatic put_value(input int depth);
    int r;
    int n;
    r = (depth >= 3) ? $urandom_range(2, 5) : $urandom_range(0, 5);
    case (r)
      0: begin
        put(jbt_pkg::CH_LBRACE);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put(jbt_pkg::CH_COMMA);
          put_ws();
          put(jbt_pkg::CH_QUOTE); put_string_body(); put(jbt_pkg::CH_QUOTE);
          put_ws(); put(jbt_pkg::CH_COLON); put_ws();
          put_value(depth + 1);
          put_ws();
        end
        put(jbt_pkg::CH_RBRACE);
      end
      1: begin
        put(jbt_pkg::CH_LBRACKET);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put(jbt_pkg::CH_COMMA);
          put_ws();
          put_value(depth + 1);
          put_ws();
        end
        put(jbt_pkg::CH_RBRACKET);
      end
      2: begin
        put(jbt_pkg::CH_QUOTE); put_string_body(); put(jbt_pkg::CH_QUOTE);
      end
      3: put_number();
      default: begin
        r = $urandom_range(0, 2);
        put_keyword(r, (r == 1) ? 5 : 4);
      end
    endcase
  endtask

  task automatic put_broken();
    int r;
    r = $urandom_range(0, 2);
    case (r)
      0: begin
        // keyword cut short, then any byte
        r = $urandom_range(0, 2);
        put_keyword(r, $urandom_range(1, (r == 1) ? 4 : 3));
        put(8'($urandom_range(0, 255)));
      end
      1: begin
        // string left open until the document ends
        put(jbt_pkg::CH_QUOTE);
        put_string_body();
      end
      default: repeat ($urandom_range(1, 10)) put(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic put_doc();
    put_ws();
    if ($urandom_range(0, 9) < 8) begin
      put_value(0);
      put_ws();
      if ($urandom_range(0, 7) == 0) put_broken();
    end else begin
      put_broken();
    end
    put(jbt_pkg::CH_NUL);
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || in_valid || token_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    string dir_doc;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: punctuation, number ended by comma, empty string, true and null,
    // false broken on its last letter, whitespace, stray byte, open string at end
    dir_doc = "{}[]:9.,\"\"truenullfalsx";
    for (int i = 0; i < dir_doc.len(); i++) put(dir_doc[i]);
    put(jbt_pkg::CH_NL);
    put(8'hFF);
    put(jbt_pkg::CH_QUOTE);
    put("a");
    put(jbt_pkg::CH_NUL);
    drain();

    // receiver holds off while the sender keeps offering token-rich bytes
    rand_bytes = 0;
    repeat (20) put(jbt_pkg::CH_COMMA);
    rx_hold = LONG_HOLD;
    while (rand_bytes < 220) put_doc();
    drain();

    // last part: no idling on either side
    calm = 1'b1;
    while (rand_bytes < 420) put_doc();
    drain();

    if (token_q.size() != 0)
      flag_error($sformatf("%0d tokens never arrived", token_q.size()));
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
